// ----- rtl/nss_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nss_pkg
// Types, constants and reset tables shared by the note step sequencer.
// ----------------------------------------------------------------------------
package nss_pkg;

  localparam int unsigned StepsDefault = 16;
  localparam int unsigned StepsMax     = 64;

  localparam logic [15:0] SpsReset = 16'd12000;
  localparam logic [6:0]  VelReset = 7'd100;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_NOTE_ON  = 3'd1,
    OP_NOTE_OFF = 3'd2,
    OP_CLOCK    = 3'd3,
    OP_PLAY     = 3'd4,
    OP_EDIT_PTR = 3'd5
  } op_e;

  typedef struct packed {
    logic       active;
    logic [6:0] velocity;
    logic [6:0] note;
  } step_t;

  // Factory pattern: a rising C major scale over the first eight steps.
  localparam logic [6:0] DefaultNotes [8] = '{
    7'd60, 7'd62, 7'd64, 7'd65, 7'd67, 7'd69, 7'd71, 7'd72
  };

  function automatic step_t default_step(input logic [5:0] idx);
    step_t s;
    s.velocity = VelReset;
    if (idx < 6'd8) begin
      s.active = 1'b1;
      s.note   = DefaultNotes[idx[2:0]];
    end else begin
      s.active = 1'b0;
      s.note   = 7'd0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nss_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nss_in_if
// Event channel into the sequencer: valid/ready plus the event fields.
// ----------------------------------------------------------------------------
interface nss_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [6:0] note;
  logic [6:0] velocity;
  logic [7:0] value;

  modport source (output valid, output opcode, output note, output velocity,
                  output value, input ready);
  modport sink   (input valid, input opcode, input note, input velocity,
                  input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/nss_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nss_out_if
// Result channel out of the sequencer: valid/ready plus voice and pointers.
// ----------------------------------------------------------------------------
interface nss_out_if;
  logic       valid;
  logic       ready;
  logic       gate;
  logic [6:0] pitch;
  logic       retrigger;
  logic [3:0] play_step;
  logic [3:0] edit_step;
  logic       recording;
  logic       playing;

  modport source (output valid, output gate, output pitch, output retrigger,
                  output play_step, output edit_step, output recording,
                  output playing, input ready);
  modport sink   (input valid, input gate, input pitch, input retrigger,
                  input play_step, input edit_step, input recording,
                  input playing, output ready);
endinterface

`default_nettype wire

// ----- rtl/note_step_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// note_step_sequencer
// Event-driven step sequencer: plays a stored pattern on sample ticks and
// records note-on events into the pattern while stopped.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake        Payload
//  in_i     in   valid/ready      opcode, note, velocity, value
//  out_o    out  valid/ready      gate, pitch, retrigger, play_step,
//                                 edit_step, recording, playing
//  cfg      in   cfg_we_i         cfg_wdata_i = sample ticks per step
//
// One event per clock is taken while the output is not stalled. Each event
// passes an input register and then a result register, whose valid flag
// marks its result. The pattern store is read ahead at the next play
// pointer, so the step data is ready for the next event. Reset is
// asynchronous and active low, and needs no clearing pass. A stalled output
// holds the result; the input register then takes a transfer only while it
// is empty, so at most two events wait inside.
// ----------------------------------------------------------------------------
module note_step_sequencer #(
  parameter int unsigned Steps = nss_pkg::StepsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  nss_in_if.sink           in_i,
  nss_out_if.source        out_o
);
  import nss_pkg::*;

  localparam int unsigned PtrW = $clog2(Steps);
  localparam logic [PtrW-1:0] LastStep = PtrW'(Steps - 1);

  // Input register.
  logic       in_vld_q;
  logic [2:0] in_op_q;
  logic [6:0] in_note_q;
  logic [6:0] in_vel_q;
  logic [7:0] in_value_q;

  // Result register.
  logic       out_vld_q;
  logic       gate_o_q;
  logic [6:0] pitch_o_q;
  logic       retrig_o_q;
  logic [3:0] play_step_q;
  logic [3:0] edit_step_q;
  logic       rec_o_q;
  logic       play_o_q;

  // Sequencer state.
  logic [15:0]     sps_q;
  logic [15:0]     cnt_q, cnt_d;
  logic [PtrW-1:0] play_ptr_q, play_ptr_d;
  logic [PtrW-1:0] edit_ptr_q, edit_ptr_d;
  logic            play_q, play_d;
  logic            rec_q, rec_d;
  logic            gate_q, gate_d;
  logic [6:0]      pitch_q, pitch_d;
  logic [6:0]      last_q, last_d;
  logic            retrig;

  logic            adv;
  logic            mem_we;
  step_t           mem_wdata;
  step_t           cur_step;
  logic [15:0]     cnt_inc;
  logic [PtrW-1:0] play_ptr_nx;
  logic [PtrW-1:0] mem_raddr;

  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  assign cnt_inc     = cnt_q + 16'd1;
  assign play_ptr_nx = (play_ptr_q == LastStep) ? '0 : play_ptr_q + PtrW'(1);

  always_comb begin
    cnt_d      = cnt_q;
    play_ptr_d = play_ptr_q;
    edit_ptr_d = edit_ptr_q;
    play_d     = play_q;
    rec_d      = rec_q;
    gate_d     = gate_q;
    pitch_d    = pitch_q;
    last_d     = last_q;
    retrig     = 1'b0;
    mem_we     = 1'b0;
    mem_wdata  = '{active: 1'b1, velocity: in_vel_q, note: in_note_q};
    case (op_e'(in_op_q))
      OP_TICK: begin
        if (play_q) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= sps_q) begin
            cnt_d = '0;
            if (last_q != 7'd0) begin
              gate_d = 1'b0;
            end
            if (cur_step.active && cur_step.note != 7'd0) begin
              gate_d  = 1'b1;
              pitch_d = cur_step.note;
              last_d  = cur_step.note;
              retrig  = 1'b1;
            end
            play_ptr_d = play_ptr_nx;
          end
        end
      end
      OP_NOTE_ON: begin
        if (!play_q) begin
          mem_we = 1'b1;
          if (edit_ptr_q == LastStep) begin
            edit_ptr_d = '0;
            rec_d      = 1'b0;
          end else begin
            edit_ptr_d = edit_ptr_q + PtrW'(1);
            rec_d      = 1'b1;
          end
          pitch_d = in_note_q;
          gate_d  = 1'b1;
          retrig  = 1'b1;
        end
      end
      OP_NOTE_OFF: begin
        if (!play_q) begin
          gate_d = 1'b0;
        end
      end
      OP_CLOCK: begin
        if (play_q) begin
          cnt_d = '0;
        end
      end
      OP_PLAY: begin
        play_d = (in_value_q != 8'd0);
        if (in_value_q != 8'd0) begin
          play_ptr_d = '0;
          cnt_d      = '0;
        end
      end
      OP_EDIT_PTR: begin
        edit_ptr_d = (in_value_q >= 8'(Steps)) ? '0 : PtrW'(in_value_q);
      end
      default: begin
      end
    endcase
  end

  // The store is read at the pointer the next event will see, so the
  // registered read data always matches the current play pointer.
  assign mem_raddr = adv ? play_ptr_d : play_ptr_q;

  nss_step_mem #(
    .Steps (Steps)
  ) u_step_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (adv && mem_we),
    .waddr_i (edit_ptr_q),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (cur_step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      sps_q      <= SpsReset;
      cnt_q      <= '0;
      play_ptr_q <= '0;
      edit_ptr_q <= '0;
      play_q     <= 1'b0;
      rec_q      <= 1'b0;
      gate_q     <= 1'b0;
      pitch_q    <= '0;
      last_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        sps_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q  <= 1'b1;
        cnt_q      <= cnt_d;
        play_ptr_q <= play_ptr_d;
        edit_ptr_q <= edit_ptr_d;
        play_q     <= play_d;
        rec_q      <= rec_d;
        gate_q     <= gate_d;
        pitch_q    <= pitch_d;
        last_q     <= last_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_op_q    <= in_i.opcode;
      in_note_q  <= in_i.note;
      in_vel_q   <= in_i.velocity;
      in_value_q <= in_i.value;
    end
    if (adv) begin
      gate_o_q    <= gate_d;
      pitch_o_q   <= pitch_d;
      retrig_o_q  <= retrig;
      play_step_q <= 4'(play_ptr_d);
      edit_step_q <= 4'(edit_ptr_d);
      rec_o_q     <= rec_d;
      play_o_q    <= play_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.gate      = gate_o_q;
  assign out_o.pitch     = pitch_o_q;
  assign out_o.retrigger = retrig_o_q;
  assign out_o.play_step = play_step_q;
  assign out_o.edit_step = edit_step_q;
  assign out_o.recording = rec_o_q;
  assign out_o.playing   = play_o_q;

endmodule

`default_nettype wire

// ----- rtl/nss_step_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nss_step_mem
// Pattern store: one write port, one registered read port. Entries that have
// never been written read as the factory pattern, tracked by valid bits.
// ----------------------------------------------------------------------------
module nss_step_mem #(
  parameter int unsigned Steps = nss_pkg::StepsDefault,
  localparam int unsigned PtrW = $clog2(Steps)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 we_i,
  input  wire logic [PtrW-1:0]      waddr_i,
  input  wire nss_pkg::step_t       wdata_i,
  input  wire logic [PtrW-1:0]      raddr_i,
  output nss_pkg::step_t            rdata_o
);
  import nss_pkg::*;

  step_t             mem [Steps];
  logic [Steps-1:0]  written_q;
  step_t             rd_q;
  logic              rd_written_q;
  logic [PtrW-1:0]   rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q      <= mem[raddr_i];
    rd_addr_q <= raddr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      rd_written_q <= written_q[raddr_i];
    end
  end

  assign rdata_o = rd_written_q ? rd_q : default_step(6'(rd_addr_q));

endmodule

`default_nettype wire
